// ===== sv/whp_pkg.sv =====
// Package with types, constants and phase codes of the WAV header parser.
package whp_pkg;

	localparam int FMT_READ_LIMIT = 40;
	localparam logic [31:0] HEADER_LEN = 32'd12;
	localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;
	localparam logic [15:0] FMT_PCM = 16'h0001;
	localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_READ_ERR = 2'd1;
	localparam logic [1:0] ST_FORMAT_ERR = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_HDR,
		PH_HDR_BAD,
		PH_CHDR,
		PH_FMT,
		PH_SKIP,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_RUN,
		DS_DONE
	} div_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] chan_count;
		logic [31:0] samp_rate;
		logic [31:0] bytes_per_sec;
		logic [15:0] frame_bytes;
		logic [15:0] samp_bits;
		logic [31:0] audio_start;
		logic [31:0] audio_len;
		logic [31:0] play_secs;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// ===== sv/whp_stream_if.sv =====
// Valid/ready channel interface carrying one payload item.
interface whp_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/whp_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module whp_divider
	import whp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	div_state_t  state_q, state_d;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [4:0]  cnt_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			DS_IDLE: if (req.start) state_d = DS_RUN;
			DS_RUN: if (cnt_q == 5'd31) state_d = DS_DONE;
			DS_DONE: state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_comb begin
		rsp.done = (state_q == DS_DONE);
		rsp.quotient = quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == DS_RUN) cnt_q <= cnt_q + 5'd1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DS_IDLE && req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (state_q == DS_RUN) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

endmodule

// ===== sv/wav_header_parser.sv =====
// Top level of the WAV header parser: byte parser, result register and divider control.
// Output: a result is registered and valid in the cycle after the byte that completes it; a data
// chunk with a nonzero byte rate first waits for the bit-serial 32-step divider to finish.
// Throughput: one byte per cycle, except while the divider runs or a result waits.
// Reset: arst_n clears the phase and all parse fields, not the result register; the parser waits for a first byte.
module wav_header_parser
	import whp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	whp_stream_if.sink   in_ch,
	whp_stream_if.source out_ch
);

	phase_t      phase_q;
	logic [31:0] pos_q, togo_q, tag_q, len_q;
	logic [15:0] fcode_q, chan_q, align_q, bits_q;
	logic [31:0] rate_q, brate_q;
	logic        fmt_seen_q;
	logic        busy_q;
	logic        out_valid_q;
	out_item_t   out_q;

	phase_t      ph;
	logic [31:0] pos, togo, tag, len;
	logic [15:0] fcode, chan, align, bits;
	logic [31:0] rate, brate;
	logic        fseen;
	logic        emit;
	logic [1:0]  emit_st;
	logic [31:0] pos_prev, take;
	logic [7:0]  b;
	logic        accept;
	out_item_t   res;
	div_req_t    dreq;
	div_rsp_t    drsp;

	whp_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign in_ch.ready = !busy_q && !out_valid_q;
	assign accept = in_ch.valid && in_ch.ready;
	assign b = in_ch.payload.data_byte;
	assign out_ch.valid = out_valid_q;
	assign out_ch.payload = out_q;

	always_comb begin
		ph = phase_q; pos = pos_q; togo = togo_q; tag = tag_q; len = len_q;
		fcode = fcode_q; chan = chan_q; rate = rate_q; brate = brate_q;
		align = align_q; bits = bits_q; fseen = fmt_seen_q;
		emit = 1'b0; emit_st = ST_OK; take = '0; pos_prev = '0;
		if (in_ch.payload.first_byte) begin
			ph = PH_HDR; pos = '0; togo = HEADER_LEN; tag = '0; len = '0;
			fcode = '0; chan = '0; rate = '0; brate = '0; align = '0; bits = '0;
			fseen = 1'b0;
		end
		if (ph >= PH_HDR && ph <= PH_SKIP) begin
			pos_prev = pos;
			pos = pos + 32'd1;
			case (ph)
				PH_HDR, PH_HDR_BAD: begin
					tag = {tag[23:0], b};
					togo = togo - 32'd1;
					if (pos_prev == 32'd3 && tag != TAG_RIFF) ph = PH_HDR_BAD;
					if (togo == '0) begin
						if (ph == PH_HDR_BAD || tag != TAG_WAVE) begin
							emit = 1'b1; emit_st = ST_FORMAT_ERR;
						end else begin
							ph = PH_CHDR; togo = CHUNK_HDR_LEN;
						end
					end
				end
				PH_CHDR: begin
					if (togo > 32'd4) tag = {tag[23:0], b};
					else len = {b, len[31:8]};
					togo = togo - 32'd1;
					if (togo == '0) begin
						take = (len < 32'(FMT_READ_LIMIT)) ? len : 32'(FMT_READ_LIMIT);
						if (tag == TAG_FMT) begin
							fcode = '0; chan = '0; rate = '0; brate = '0; align = '0;
							bits = '0; tag = '0; togo = take;
							if (take == '0) begin
								emit = 1'b1; emit_st = ST_FORMAT_ERR;
							end else ph = PH_FMT;
						end else if (tag == TAG_DATA) begin
							emit = 1'b1; emit_st = fseen ? ST_OK : ST_FORMAT_ERR;
						end else if (len == '0) begin
							ph = PH_CHDR; togo = CHUNK_HDR_LEN;
						end else begin
							ph = PH_SKIP; togo = len;
						end
					end
				end
				PH_FMT: begin
					case (tag)
						32'd0: fcode[7:0] = b;
						32'd1: fcode[15:8] = b;
						32'd2: chan[7:0] = b;
						32'd3: chan[15:8] = b;
						32'd4: rate[7:0] = b;
						32'd5: rate[15:8] = b;
						32'd6: rate[23:16] = b;
						32'd7: rate[31:24] = b;
						32'd8: brate[7:0] = b;
						32'd9: brate[15:8] = b;
						32'd10: brate[23:16] = b;
						32'd11: brate[31:24] = b;
						32'd12: align[7:0] = b;
						32'd13: align[15:8] = b;
						32'd14: bits[7:0] = b;
						32'd15: bits[15:8] = b;
						default: ;
					endcase
					tag = tag + 32'd1;
					togo = togo - 32'd1;
					if (togo == '0) begin
						take = (len < 32'(FMT_READ_LIMIT)) ? len : 32'(FMT_READ_LIMIT);
						if (fcode != FMT_PCM && fcode != FMT_EXTENSIBLE) begin
							emit = 1'b1; emit_st = ST_FORMAT_ERR;
						end else begin
							fseen = 1'b1;
							if (len - take == '0) begin
								ph = PH_CHDR; togo = CHUNK_HDR_LEN;
							end else begin
								ph = PH_SKIP; togo = len - take;
							end
						end
					end
				end
				default: begin
					togo = togo - 32'd1;
					if (togo == '0) begin
						ph = PH_CHDR; togo = CHUNK_HDR_LEN;
					end
				end
			endcase
			if (!emit && in_ch.payload.last_byte) begin
				emit = 1'b1;
				emit_st = (ph == PH_HDR || ph == PH_HDR_BAD || ph == PH_FMT) ?
					ST_READ_ERR : ST_FORMAT_ERR;
			end
			if (emit) ph = PH_DONE;
		end
	end

	always_comb begin
		dreq.start = accept && emit && emit_st == ST_OK && brate != '0;
		dreq.dividend = len;
		dreq.divisor = brate;
	end

	always_comb begin
		res = '0;
		res.status = emit_st;
		if (emit_st == ST_OK) begin
			res.chan_count = chan;
			res.samp_rate = rate;
			res.bytes_per_sec = brate;
			res.frame_bytes = align;
			res.samp_bits = bits;
			res.audio_start = pos;
			res.audio_len = len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; pos_q <= '0; togo_q <= '0; tag_q <= '0; len_q <= '0;
			fcode_q <= '0; chan_q <= '0; rate_q <= '0; brate_q <= '0;
			align_q <= '0; bits_q <= '0; fmt_seen_q <= 1'b0;
			busy_q <= 1'b0; out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= ph; pos_q <= pos; togo_q <= togo; tag_q <= tag; len_q <= len;
				fcode_q <= fcode; chan_q <= chan; rate_q <= rate; brate_q <= brate;
				align_q <= align; bits_q <= bits; fmt_seen_q <= fseen;
				if (dreq.start) busy_q <= 1'b1;
				else if (emit) out_valid_q <= 1'b1;
			end
			if (busy_q && drsp.done) begin
				busy_q <= 1'b0;
				out_valid_q <= 1'b1;
			end
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) out_q <= res;
		if (busy_q && drsp.done) out_q.play_secs <= drsp.quotient;
	end

endmodule

// ===== dv/wav_header_parser_tb.sv =====
// Testbench for the WAV header parser: byte streams in, header results checked against a predictor.
module wav_header_parser_tb;
	import whp_pkg::*;

	logic clk;
	logic arst_n;
	bit hold_long;
	int idle_cycles;

	whp_stream_if #(.payload_t(in_item_t)) in_ch ();
	whp_stream_if #(.payload_t(out_item_t)) out_ch ();

	wav_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	class header_scoreboard;
		phase_t phase;
		logic [31:0] pos;
		logic [31:0] to_go;
		logic [31:0] tag;
		logic [31:0] len;
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [31:0] rate;
		logic [31:0] brate;
		logic [15:0] align;
		logic [15:0] bits;
		bit fmt_ok;
		bit produced;
		out_item_t pending[$];
		int errors;

		function void clear();
			phase = PH_IDLE;
			pos = 0;
			to_go = 0;
			tag = 0;
			len = 0;
			fmt_code = 0;
			chans = 0;
			rate = 0;
			brate = 0;
			align = 0;
			bits = 0;
			fmt_ok = 0;
		endfunction

		function void report(logic [1:0] st);
			out_item_t r;
			r = '0;
			r.status = st;
			if (st == ST_OK) begin
				r.chan_count = chans;
				r.samp_rate = rate;
				r.bytes_per_sec = brate;
				r.frame_bytes = align;
				r.samp_bits = bits;
				r.audio_start = pos;
				r.audio_len = len;
				r.play_secs = (brate != 0) ? len / brate : 32'd0;
			end
			pending.push_back(r);
			produced = 1;
			phase = PH_DONE;
		endfunction

		function logic [31:0] fmt_len();
			return (len < FMT_READ_LIMIT) ? len : FMT_READ_LIMIT;
		endfunction

		function void goto_next(logic [31:0] n);
			if (n == 0) begin
				phase = PH_CHDR;
				to_go = CHUNK_HDR_LEN;
			end else begin
				phase = PH_SKIP;
				to_go = n;
			end
		endfunction

		function void end_fmt();
			if (fmt_code != FMT_PCM && fmt_code != FMT_EXTENSIBLE) begin
				report(ST_FORMAT_ERR);
			end else begin
				fmt_ok = 1;
				goto_next(len - fmt_len());
			end
		endfunction

		function void note_byte(in_item_t it);
			logic [31:0] was;
			logic [31:0] b;
			b = {24'd0, it.data_byte};
			produced = 0;
			if (it.first_byte) begin
				clear();
				phase = PH_HDR;
				to_go = HEADER_LEN;
			end
			if (phase == PH_IDLE || phase == PH_DONE)
				return;
			was = pos;
			pos = pos + 1;
			case (phase)
				PH_HDR, PH_HDR_BAD: begin
					tag = {tag[23:0], it.data_byte};
					to_go--;
					if (was == 3 && tag != TAG_RIFF)
						phase = PH_HDR_BAD;
					if (to_go == 0) begin
						if (phase == PH_HDR_BAD || tag != TAG_WAVE) begin
							report(ST_FORMAT_ERR);
						end else begin
							phase = PH_CHDR;
							to_go = CHUNK_HDR_LEN;
						end
					end
				end
				PH_CHDR: begin
					if (to_go > 4)
						tag = {tag[23:0], it.data_byte};
					else
						len = {it.data_byte, len[31:8]};
					to_go--;
					if (to_go == 0) begin
						if (tag == TAG_FMT) begin
							fmt_code = 0;
							chans = 0;
							rate = 0;
							brate = 0;
							align = 0;
							bits = 0;
							tag = 0;
							to_go = fmt_len();
							if (to_go == 0)
								end_fmt();
							else
								phase = PH_FMT;
						end else if (tag == TAG_DATA) begin
							report(fmt_ok ? ST_OK : ST_FORMAT_ERR);
						end else begin
							goto_next(len);
						end
					end
				end
				PH_FMT: begin
					if (tag < 2)
						fmt_code = fmt_code | 16'(b << (8 * tag));
					else if (tag < 4)
						chans = chans | 16'(b << (8 * (tag - 2)));
					else if (tag < 8)
						rate = rate | (b << (8 * (tag - 4)));
					else if (tag < 12)
						brate = brate | (b << (8 * (tag - 8)));
					else if (tag < 14)
						align = align | 16'(b << (8 * (tag - 12)));
					else if (tag < 16)
						bits = bits | 16'(b << (8 * (tag - 14)));
					tag++;
					to_go--;
					if (to_go == 0)
						end_fmt();
				end
				default: begin
					to_go--;
					if (to_go == 0)
						goto_next(0);
				end
			endcase
			if (!produced && it.last_byte) begin
				if (phase == PH_HDR || phase == PH_HDR_BAD || phase == PH_FMT)
					report(ST_READ_ERR);
				else
					report(ST_FORMAT_ERR);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status ||
					got.chan_count !== want.chan_count ||
					got.samp_rate !== want.samp_rate ||
					got.bytes_per_sec !== want.bytes_per_sec ||
					got.frame_bytes !== want.frame_bytes ||
					got.samp_bits !== want.samp_bits ||
					got.audio_start !== want.audio_start ||
					got.audio_len !== want.audio_len ||
					got.play_secs !== want.play_secs) begin
				$display("%0t: result mismatch, expected %h, actual %h", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	header_scoreboard sb;
	byte unsigned file_q[$];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic put_le(int unsigned v, int n);
		for (int i = 0; i < n; i++)
			file_q.push_back(8'((v >> (8 * i)) & 8'hFF));
	endtask

	task automatic put_tag(logic [31:0] t);
		for (int i = 3; i >= 0; i--)
			file_q.push_back(t[8 * i +: 8]);
	endtask

	task automatic send_stream(bit end_last);
		int gap;
		int burst;
		in_item_t it;
		burst = $urandom_range(1, 20);
		for (int i = 0; i < file_q.size(); i++) begin
			if (burst == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
				if (gap > 0) begin
					in_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 20);
			end
			it.data_byte = file_q[i];
			it.first_byte = (i == 0);
			it.last_byte = end_last && (i == file_q.size() - 1);
			in_ch.valid <= 1'b1;
			in_ch.payload <= it;
			@(posedge clk);
			while (!in_ch.ready)
				@(posedge clk);
			burst--;
		end
		in_ch.valid <= 1'b0;
		@(posedge clk);
		file_q.delete();
	endtask

	task automatic build_file(int kind);
		int unsigned brate;
		int unsigned fsize;
		int n;
		put_tag(TAG_RIFF);
		put_le($urandom, 4);
		put_tag(TAG_WAVE);
		if ($urandom_range(0, 3) == 0) begin
			put_tag(32'h4C495354);
			n = $urandom_range(0, 6);
			put_le(n, 4);
			repeat (n) file_q.push_back(8'($urandom));
		end
		fsize = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 60) : 16;
		if (kind == 1)
			fsize = 0;
		put_tag(TAG_FMT);
		put_le(fsize, 4);
		brate = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 200000);
		for (int i = 0; i < fsize; i++) begin
			if (i == 0)
				file_q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) :
					($urandom_range(0, 1) ? 8'h01 : 8'hFE));
			else if (i == 1)
				file_q.push_back((file_q[file_q.size() - 1] == 8'hFE) ? 8'hFF : 8'h00);
			else if (i >= 8 && i < 12)
				file_q.push_back(8'((brate >> (8 * (i - 8))) & 8'hFF));
			else
				file_q.push_back(8'($urandom));
		end
		if (kind == 2)
			put_tag(32'h6A756E6B);
		put_tag(TAG_DATA);
		put_le($urandom, 4);
		if (kind == 3) begin
			n = $urandom_range(1, file_q.size() - 1);
			while (file_q.size() > n)
				void'(file_q.pop_back());
		end else if (kind == 4) begin
			n = $urandom_range(0, file_q.size() - 1);
			file_q[n] = 8'($urandom);
		end
		repeat ($urandom_range(0, 3)) file_q.push_back(8'($urandom));
	endtask

	initial begin
		int sent;
		arst_n = 0;
		hold_long = 0;
		in_ch.valid = 0;
		in_ch.payload = '0;
		sb = new();
		sb.clear();
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed streams: bad RIFF, bad WAVE, data before fmt, extremes and early ends.
		file_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 0, 0, 0, 0, 8'h57, 8'h41, 8'h56, 8'h45};
		send_stream(0);
		put_tag(TAG_RIFF);
		put_le(32'hFFFFFFFF, 4);
		put_tag(32'hFFFFFFFF);
		send_stream(0);
		put_tag(TAG_RIFF);
		put_le(0, 4);
		put_tag(TAG_WAVE);
		put_tag(TAG_DATA);
		put_le(32'hFFFFFFFF, 4);
		send_stream(0);
		put_tag(TAG_RIFF);
		put_le(0, 4);
		put_tag(TAG_WAVE);
		put_tag(TAG_FMT);
		put_le(16, 4);
		put_le(FMT_EXTENSIBLE, 2);
		put_le(16'hFFFF, 2);
		put_le(32'hFFFFFFFF, 4);
		put_le(1, 4);
		put_le(16'hFFFF, 2);
		put_le(16'hFFFF, 2);
		put_tag(TAG_DATA);
		put_le(32'hFFFFFFFF, 4);
		send_stream(1);
		file_q = '{8'h52, 8'h49, 8'h46};
		send_stream(1);
		file_q = '{8'h12};
		send_stream(1);
		// Bytes with no first marker while idle are ignored.
		in_ch.valid <= 1'b1;
		in_ch.payload <= '{8'hAA, 1'b0, 1'b1};
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		sent = 0;
		while (sent < 1550) begin
			build_file($urandom_range(0, 5));
			sent += file_q.size();
			send_stream($urandom_range(0, 7) == 0);
			if (sent > 400 && !hold_long) begin
				hold_long = 1;
			end
		end
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Receiver stall pattern, with one long hold-off during the run.
	initial begin
		int phase_cnt;
		out_ch.ready = 0;
		phase_cnt = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase_cnt++;
			if (hold_long && phase_cnt > 0 && phase_cnt < 1000000) begin
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
				phase_cnt = 1000000;
			end
			out_ch.ready <= (phase_cnt % 7 < 4) || (phase_cnt % 200 > 150);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_byte(in_ch.payload);
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.payload);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("TB_ERROR");
			$finish;
		end
	end
endmodule
